// ===== src/bpeq_pkg.sv =====
// bpeq_pkg: shared codes, widths and types for the button press event qualifier.
// No dependencies; compiled first.
package bpeq_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 8;
  localparam int CODE_W     = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_CNT = 3'd4;

  // Mode codes
  localparam logic [CODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [CODE_W-1:0] MODE_DEBOUNCE = 3'd1;
  localparam logic [CODE_W-1:0] MODE_PRESSED  = 3'd2;
  localparam logic [CODE_W-1:0] MODE_REPEAT   = 3'd3;
  localparam logic [CODE_W-1:0] MODE_RELEASE  = 3'd4;
  localparam logic [CODE_W-1:0] MODE_OFF      = 3'd5;

  // Event codes
  localparam logic [CODE_W-1:0] EV_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] EV_PRESS  = 3'd1;
  localparam logic [CODE_W-1:0] EV_LONG   = 3'd2;
  localparam logic [CODE_W-1:0] EV_REPEAT = 3'd3;
  localparam logic [CODE_W-1:0] EV_TOGGLE = 3'd4;
  localparam logic [CODE_W-1:0] EV_OFF    = 3'd5;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE   = 16'd20;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_PRESS = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_REPEAT     = 16'd200;
  localparam logic [CFG_DATA_W-1:0] RST_TOGGLE     = 16'd100;
  localparam logic [COUNT_W-1:0]    RST_TOGGLE_CNT = 8'd0;

  // Configuration register set
  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_time;
    logic [CFG_DATA_W-1:0] long_press_time;
    logic [CFG_DATA_W-1:0] repeat_time;
    logic [CFG_DATA_W-1:0] toggle_time;
    logic [COUNT_W-1:0]    toggle_count;
  } bpeq_cfg_t;

endpackage

// ===== src/bpeq_in_if.sv =====
// bpeq_in_if: request channel carrying one pin sample per tick.
// Standalone valid/ready interface, no dependencies.
interface bpeq_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== src/bpeq_out_if.sv =====
// bpeq_out_if: result channel carrying event and mode codes.
// Standalone valid/ready interface, no dependencies.
interface bpeq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] mode_now;

  modport source (output valid, output event_res, output mode_now, input ready);
  modport sink   (input valid, input event_res, input mode_now, output ready);
endinterface

// ===== src/bpeq_step.sv =====
// bpeq_step: next-state and event logic for one tick of the qualifier.
// Purely combinational; uses bpeq_pkg.
module bpeq_step #(
  parameter int TIME_BITS = 16
) (
  input  bpeq_pkg::bpeq_cfg_t               cfg,
  input  logic                              pin_level,
  input  logic [2:0]                        mode,
  input  logic [TIME_BITS:0]                elapsed,
  input  logic [7:0]                        pulses,
  output logic [2:0]                        mode_nxt,
  output logic [TIME_BITS:0]                elapsed_nxt,
  output logic [7:0]                        pulses_nxt,
  output logic [2:0]                        event_nxt
);
  import bpeq_pkg::*;

  localparam int CNT_W = TIME_BITS + 1;

  logic                  low;
  logic [CFG_DATA_W-1:0] limit_raw;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      elapsed_inc;
  logic                  past;
  logic [COUNT_W-1:0]    pulses_inc;

  assign low = ~pin_level;

  // Period for the current mode, before masking to the timer width
  always_comb begin
    case (mode)
      MODE_DEBOUNCE: limit_raw = cfg.debounce_time;
      MODE_PRESSED:  limit_raw = cfg.long_press_time;
      MODE_REPEAT:   limit_raw = cfg.repeat_time;
      default:       limit_raw = cfg.toggle_time;
    endcase
  end

  // Mask the period to TIME_BITS bits
  generate
    if (TIME_BITS >= CFG_DATA_W) begin : g_wide
      assign limit = CNT_W'(limit_raw);
    end else begin : g_narrow
      assign limit = {1'b0, limit_raw[TIME_BITS-1:0]};
    end
  endgenerate

  // Saturating tick count and period compare
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign past        = elapsed_inc > limit;
  assign pulses_inc  = pulses + 1'b1;

  always_comb begin
    mode_nxt    = mode;
    elapsed_nxt = elapsed;
    pulses_nxt  = pulses;
    event_nxt   = EV_NONE;
    case (mode)
      MODE_DEBOUNCE: begin
        elapsed_nxt = elapsed_inc;
        if (past) begin
          if (low) begin
            mode_nxt    = MODE_PRESSED;
            elapsed_nxt = '0;
            event_nxt   = EV_PRESS;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_PRESSED, MODE_REPEAT: begin
        if (!low) begin
          mode_nxt    = MODE_RELEASE;
          elapsed_nxt = '0;
          pulses_nxt  = '0;
        end else begin
          elapsed_nxt = elapsed_inc;
          if (past) begin
            event_nxt   = (mode == MODE_PRESSED) ? EV_LONG : EV_REPEAT;
            mode_nxt    = MODE_REPEAT;
            elapsed_nxt = '0;
          end
        end
      end
      MODE_RELEASE: begin
        // count reached or a new press: stop pulsing
        if (pulses >= cfg.toggle_count || low) begin
          mode_nxt = MODE_OFF;
        end else begin
          elapsed_nxt = elapsed_inc;
          if (past) begin
            elapsed_nxt = '0;
            pulses_nxt  = pulses_inc;
            event_nxt   = EV_TOGGLE;
            if (pulses_inc >= cfg.toggle_count) begin
              mode_nxt = MODE_OFF;
            end
          end
        end
      end
      MODE_OFF: begin
        mode_nxt  = MODE_IDLE;
        event_nxt = EV_OFF;
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (low) begin
          mode_nxt    = MODE_DEBOUNCE;
          elapsed_nxt = '0;
        end
      end
    endcase
  end

endmodule

// ===== src/button_press_event_qualifier.sv =====
// Button press event qualifier: takes one active-low pin sample per tick and
// returns one result per sample (event code and resulting mode). It accepts a
// sample every clock cycle while the result channel is not stalled; a sample is
// held in the input register, the tick's state update is done combinationally
// from it, and the event and mode are captured in the result register as the
// state is committed. Back-pressure on the result channel stalls the input after
// one sample is held. Configuration writes are registered and are to be made
// only while no sample is in flight.
module button_press_event_qualifier #(
  parameter int TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bpeq_in_if.sink                             in_ch,
  bpeq_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [bpeq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpeq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bpeq_pkg::*;

  localparam int CNT_W = TIME_BITS + 1;

  bpeq_cfg_t           cfg_r;
  logic                in_valid_r;
  logic                in_pin_r;
  logic                out_valid_r;
  logic [CODE_W-1:0]   out_event_r;
  logic [CODE_W-1:0]   out_mode_r;
  logic [CODE_W-1:0]   mode_r;
  logic [CNT_W-1:0]    elapsed_r;
  logic [COUNT_W-1:0]  pulses_r;

  logic [CODE_W-1:0]   mode_nxt;
  logic [CNT_W-1:0]    elapsed_nxt;
  logic [COUNT_W-1:0]  pulses_nxt;
  logic [CODE_W-1:0]   event_nxt;
  logic                advance;

  // Handshake: a held sample moves on when the result slot is free or draining
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_event_r;
  assign out_ch.mode_now  = out_mode_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= RST_DEBOUNCE;
      cfg_r.long_press_time <= RST_LONG_PRESS;
      cfg_r.repeat_time     <= RST_REPEAT;
      cfg_r.toggle_time     <= RST_TOGGLE;
      cfg_r.toggle_count    <= RST_TOGGLE_CNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce_time   <= cfg_data;
        CFG_LONG_PRESS: cfg_r.long_press_time <= cfg_data;
        CFG_REPEAT:     cfg_r.repeat_time     <= cfg_data;
        CFG_TOGGLE:     cfg_r.toggle_time     <= cfg_data;
        CFG_TOGGLE_CNT: cfg_r.toggle_count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_pin_r <= in_ch.pin_level;
    end
  end

  // Tick logic
  bpeq_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg         (cfg_r),
    .pin_level   (in_pin_r),
    .mode        (mode_r),
    .elapsed     (elapsed_r),
    .pulses      (pulses_r),
    .mode_nxt    (mode_nxt),
    .elapsed_nxt (elapsed_nxt),
    .pulses_nxt  (pulses_nxt),
    .event_nxt   (event_nxt)
  );

  // Qualifier state, committed once per sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      elapsed_r <= '0;
      pulses_r  <= '0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      pulses_r  <= pulses_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= event_nxt;
      out_mode_r  <= mode_nxt;
    end
  end

  // Checks
  a_off_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_OFF |-> out_mode_r == MODE_IDLE)
    else $error("off event without return to idle");

  a_press_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_PRESS |-> out_mode_r == MODE_PRESSED)
    else $error("press event outside pressed mode");

  a_hold_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r == EV_LONG || out_event_r == EV_REPEAT)
    |-> out_mode_r == MODE_REPEAT)
    else $error("long or repeat event outside repeat mode");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_mode_r == mode_r)
    else $error("result mode differs from committed mode");

endmodule
